FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// assertion helpers shared by the yrl design files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// clocked check, disabled while reset is asserted
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked check with no reset qualification
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

FILE: hdl/yrl_pkg.sv
// ----------------------------------------------------------------------------
// yrl_pkg
// shared types, constants and sigmoid table for the region logistic block
// ----------------------------------------------------------------------------
package yrl_pkg;

    localparam int DATA_W      = 16;
    localparam int CLASS_W     = 8;
    localparam int CH_W        = 9;
    localparam int SEG_W       = 5;
    localparam int FRAC_W      = 7;
    localparam int SIG_W       = 9;
    localparam int SEG_COUNT   = 32;
    localparam int TAB_IDX_W   = 6;
    // top bit of the in-range field: x in [-2048,2047] means bits [15:11] agree
    localparam int RANGE_MSB   = 11;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = 1;
    localparam int QCNT_W      = 2;

    localparam logic [CLASS_W-1:0] CLASS_RESET    = 8'd80;
    localparam logic [CH_W-1:0]    EXTRA_CHANNELS = 9'd5;
    localparam logic [CH_W-1:0]    WIDTH_CHANNEL  = 9'd2;
    localparam logic [CH_W-1:0]    HEIGHT_CHANNEL = 9'd3;
    localparam logic [CH_W-1:0]    MAX_CHANNEL    = 9'd259;
    localparam logic [SIG_W-1:0]   SIG_ONE        = 9'd256;
    localparam logic [DATA_W-1:0]  INTERP_ROUND   = 16'd64;

    // logistic at breakpoints -8.0, -7.5, ... +8.0, scaled by 256
    localparam logic [SIG_W-1:0] SIG_TABLE [0:SEG_COUNT] = '{
        9'd0,   9'd0,   9'd0,   9'd0,   9'd1,   9'd1,   9'd2,   9'd3,
        9'd5,   9'd8,   9'd12,  9'd19,  9'd31,  9'd47,  9'd69,  9'd97,
        9'd128, 9'd159, 9'd187, 9'd209, 9'd225, 9'd237, 9'd244, 9'd248,
        9'd251, 9'd253, 9'd254, 9'd255, 9'd255, 9'd256, 9'd256, 9'd256,
        9'd256
    };

    typedef enum logic [1:0] {
        KIND_PASS,
        KIND_LOW,
        KIND_HIGH,
        KIND_CURVE
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [DATA_W-1:0]   sample;
        logic [SEG_W-1:0]    seg;
        logic [FRAC_W-1:0]   frac;
    } t_entry;

endpackage

FILE: hdl/yrl_front.sv
// ----------------------------------------------------------------------------
// yrl_front
// channel tracking, class count register and element classification
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module yrl_front (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    input  logic signed [yrl_pkg::DATA_W-1:0] i_sample_in,
    input  logic                              i_pixel_start,
    input  logic                              i_cfg_we,
    input  logic [yrl_pkg::CLASS_W-1:0]       i_cfg_data,
    input  logic                              i_queue_full,
    output logic                              o_stall,
    output logic                              o_push,
    output yrl_pkg::t_entry                   o_entry
);

    logic [yrl_pkg::CLASS_W-1:0] r_class_count;
    logic [yrl_pkg::CH_W-1:0]    r_box_channel;
    logic [yrl_pkg::CH_W-1:0]    n_box_channel;
    logic [yrl_pkg::CH_W-1:0]    w_channel;
    logic [yrl_pkg::CH_W-1:0]    w_period;
    logic [yrl_pkg::CH_W-1:0]    w_chan_inc;
    logic                        w_act;
    logic                        w_in_range;

    assign o_stall = i_queue_full;
    assign o_push  = i_valid && !i_queue_full;

    always_comb begin
        w_channel  = i_pixel_start ? '0 : r_box_channel;
        w_period   = {1'b0, r_class_count} + yrl_pkg::EXTRA_CHANNELS;
        w_chan_inc = w_channel + 1'b1;
        w_act      = (w_channel != yrl_pkg::WIDTH_CHANNEL) &&
                     (w_channel != yrl_pkg::HEIGHT_CHANNEL);
        // wrap once the period is reached or passed
        n_box_channel = (w_chan_inc >= w_period) ? '0 : w_chan_inc;

        w_in_range = (i_sample_in[yrl_pkg::DATA_W-1:yrl_pkg::RANGE_MSB] == '0) ||
                     (i_sample_in[yrl_pkg::DATA_W-1:yrl_pkg::RANGE_MSB] == '1);

        o_entry.sample = i_sample_in;
        // segment = (x + 2048) >> 7, offset inside it = low seven bits
        o_entry.seg  = {~i_sample_in[yrl_pkg::RANGE_MSB],
                        i_sample_in[yrl_pkg::RANGE_MSB-1:yrl_pkg::FRAC_W]};
        o_entry.frac = i_sample_in[yrl_pkg::FRAC_W-1:0];
        if (!w_act) begin
            o_entry.kind = yrl_pkg::KIND_PASS;
        end else if (w_in_range) begin
            o_entry.kind = yrl_pkg::KIND_CURVE;
        end else if (i_sample_in[yrl_pkg::DATA_W-1]) begin
            o_entry.kind = yrl_pkg::KIND_LOW;
        end else begin
            o_entry.kind = yrl_pkg::KIND_HIGH;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_class_count <= yrl_pkg::CLASS_RESET;
            r_box_channel <= '0;
        end else begin
            if (i_cfg_we) begin
                r_class_count <= i_cfg_data;
            end
            if (o_push) begin
                r_box_channel <= n_box_channel;
            end
        end
    end

    `ASSERT_CLK(a_channel_bound, i_clk, i_rst_n, r_box_channel <= yrl_pkg::MAX_CHANNEL, "channel counter beyond largest period")

endmodule

FILE: hdl/yrl_queue.sv
// ----------------------------------------------------------------------------
// yrl_queue
// two-entry queue between classification and evaluation
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module yrl_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  yrl_pkg::t_entry i_entry,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_nonempty,
    output yrl_pkg::t_entry o_entry
);

    yrl_pkg::t_entry             r_mem [yrl_pkg::QUEUE_DEPTH];
    logic [yrl_pkg::QPTR_W-1:0]  r_wr_ptr;
    logic [yrl_pkg::QPTR_W-1:0]  r_rd_ptr;
    logic [yrl_pkg::QCNT_W-1:0]  r_count;

    assign o_full     = (r_count == yrl_pkg::QCNT_W'(yrl_pkg::QUEUE_DEPTH));
    assign o_nonempty = (r_count != '0);
    assign o_entry    = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    `ASSERT_CLK(a_no_overflow, i_clk, i_rst_n, !(i_push && o_full), "push into full queue")
    `ASSERT_CLK(a_no_underflow, i_clk, i_rst_n, !(i_pop && !o_nonempty), "pop from empty queue")

endmodule

FILE: hdl/yrl_back.sv
// ----------------------------------------------------------------------------
// yrl_back
// sigmoid interpolation and output register
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module yrl_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_queue_nonempty,
    input  yrl_pkg::t_entry                   i_entry,
    input  logic                              i_stall,
    output logic                              o_pop,
    output logic                              o_valid,
    output logic signed [yrl_pkg::DATA_W-1:0] o_sample_out,
    output logic                              o_was_activated
);

    logic                           r_valid;
    logic [yrl_pkg::DATA_W-1:0]     r_sample;
    logic                           r_act;
    logic [yrl_pkg::TAB_IDX_W-1:0]  w_idx;
    logic [yrl_pkg::TAB_IDX_W-1:0]  w_idx_nxt;
    logic [yrl_pkg::SIG_W-1:0]      w_y0;
    logic [yrl_pkg::SIG_W-1:0]      w_y1;
    logic [yrl_pkg::SIG_W-1:0]      w_diff;
    logic [yrl_pkg::DATA_W-1:0]     w_prod;
    logic [yrl_pkg::DATA_W-1:0]     w_sum;
    logic [yrl_pkg::SIG_W-1:0]      w_curve;
    logic [yrl_pkg::DATA_W-1:0]     w_result;
    logic                           w_act;

    assign o_pop = i_queue_nonempty && (!r_valid || !i_stall);

    always_comb begin
        w_idx     = {1'b0, i_entry.seg};
        w_idx_nxt = w_idx + 1'b1;
        w_y0      = yrl_pkg::SIG_TABLE[w_idx];
        w_y1      = yrl_pkg::SIG_TABLE[w_idx_nxt];
        // table is monotone, so the step is never negative
        w_diff    = w_y1 - w_y0;
        // widen both operands so the full product is kept
        w_prod    = yrl_pkg::DATA_W'(w_diff) * yrl_pkg::DATA_W'(i_entry.frac);
        w_sum     = {w_y0, {yrl_pkg::FRAC_W{1'b0}}} + w_prod + yrl_pkg::INTERP_ROUND;
        w_curve   = w_sum[yrl_pkg::SIG_W+yrl_pkg::FRAC_W-1:yrl_pkg::FRAC_W];

        w_act = 1'b1;
        case (i_entry.kind)
            yrl_pkg::KIND_PASS: begin
                w_result = i_entry.sample;
                w_act    = 1'b0;
            end
            yrl_pkg::KIND_LOW: begin
                w_result = '0;
            end
            yrl_pkg::KIND_HIGH: begin
                w_result = {{(yrl_pkg::DATA_W-yrl_pkg::SIG_W){1'b0}}, yrl_pkg::SIG_ONE};
            end
            yrl_pkg::KIND_CURVE: begin
                w_result = {{(yrl_pkg::DATA_W-yrl_pkg::SIG_W){1'b0}}, w_curve};
            end
            default: begin
                w_result = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_sample <= w_result;
            r_act    <= w_act;
        end
    end

    assign o_valid         = r_valid;
    assign o_sample_out    = r_sample;
    assign o_was_activated = r_act;

    `ASSERT_CLK(a_sig_bound, i_clk, i_rst_n, (r_valid && r_act) |-> (r_sample <= yrl_pkg::DATA_W'(yrl_pkg::SIG_ONE)), "activated word above one")

endmodule

FILE: hdl/yolo_region_logistic.sv
// ----------------------------------------------------------------------------
// yolo_region_logistic
// logistic activation stage of a region layer on a stream of q8.8 words
// ----------------------------------------------------------------------------
// The block takes one signed q8.8 tensor word per clock, when not stalled, in
// channel order and returns one word per input word, in order. A channel
// counter runs through class_count+5 channels and wraps; i_pixel_start forces
// the current word to channel 0. Words on channels 2 and 3 (box width and
// height) pass through untouched with o_was_activated low; every other word is
// replaced by a 32-segment piecewise-linear sigmoid over [-8,8), giving 0..256,
// and clamps to 0 below and 256 at or above that range. Sustained rate is one
// word per clock while neither side stalls. o_valid rises once a word has gone
// through the queue into the output register of the evaluation stage, which
// does two adjacent table reads and one 9x7 multiply per word. A two-entry
// queue sits between classification and evaluation, so input keeps flowing
// while the output side is stalled until the queue holds two words. The user
// must write class_count through i_cfg_we/i_cfg_data only while the stream is
// idle; the block does not enforce this. class_count resets to 80.
// ----------------------------------------------------------------------------
module yolo_region_logistic (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input word channel
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic signed [yrl_pkg::DATA_W-1:0] i_sample_in,
    input  logic                              i_pixel_start,
    // result word channel
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic signed [yrl_pkg::DATA_W-1:0] o_sample_out,
    output logic                              o_was_activated,
    // class count register
    input  logic                              i_cfg_we,
    input  logic [yrl_pkg::CLASS_W-1:0]       i_cfg_data
);

    // front to queue
    logic            w_push;
    yrl_pkg::t_entry w_push_entry;
    logic            w_queue_full;
    // queue to back
    logic            w_pop;
    logic            w_queue_nonempty;
    yrl_pkg::t_entry w_head_entry;

    // channel counter, config register and classification
    yrl_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_sample_in   (i_sample_in),
        .i_pixel_start (i_pixel_start),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_queue_full  (w_queue_full),
        .o_stall       (o_stall),
        .o_push        (w_push),
        .o_entry       (w_push_entry)
    );

    // decouples input acceptance from output stalls
    yrl_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_entry    (w_push_entry),
        .i_pop      (w_pop),
        .o_full     (w_queue_full),
        .o_nonempty (w_queue_nonempty),
        .o_entry    (w_head_entry)
    );

    // table lookup, interpolation and output register
    yrl_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_queue_nonempty (w_queue_nonempty),
        .i_entry          (w_head_entry),
        .i_stall          (i_stall),
        .o_pop            (w_pop),
        .o_valid          (o_valid),
        .o_sample_out     (o_sample_out),
        .o_was_activated  (o_was_activated)
    );

endmodule
